/* hw/rtl/b64d_pkg.sv */
// Package for the padded base64url decoder: item types, status codes,
// alphabet constants and the character-to-sextet map. No dependencies.
package b64d_pkg;

    localparam logic [7:0] CHAR_DASH       = 8'h2D;  // '-'
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;  // '_'
    localparam logic [7:0] CHAR_PAD        = 8'h3D;  // '='
    localparam logic [5:0] SEXTET_DASH       = 6'd62;
    localparam logic [5:0] SEXTET_UNDERSCORE = 6'd63;
    localparam logic [5:0] LOWER_BASE        = 6'd26;
    localparam logic [5:0] DIGIT_BASE        = 6'd52;
    localparam logic [7:0] BYTE_MASK         = 8'hFF;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_LENGTH = 2'd1,
        ST_BAD_CHAR   = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] in_char;
        logic       final_char;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [1:0] status;
        logic       end_of_run;
    } out_item_t;

    // One group's worth of work for the back end
    typedef struct packed {
        logic [23:0] triple;
        logic [1:0]  nbytes;
        logic        eor;
        status_t     status;
    } group_cmd_t;

    // Bit 6 set marks a character outside the alphabet
    function automatic logic [6:0] map_sextet(input logic [7:0] c);
        logic [6:0] r;
        r = 7'h40;
        if (c inside {[8'h41:8'h5A]}) begin
            r = {1'b0, 6'(c - 8'h41)};
        end
        else if (c inside {[8'h61:8'h7A]}) begin
            r = {1'b0, 6'(c - 8'h61) + LOWER_BASE};
        end
        else if (c inside {[8'h30:8'h39]}) begin
            r = {1'b0, 6'(c - 8'h30) + DIGIT_BASE};
        end
        else if (c == CHAR_DASH) begin
            r = {1'b0, SEXTET_DASH};
        end
        else if (c == CHAR_UNDERSCORE) begin
            r = {1'b0, SEXTET_UNDERSCORE};
        end
        return r;
    endfunction

endpackage

/* hw/rtl/b64d_chan_if.sv */
// Valid/ready channel interface carrying one payload of type T.
// Depends on nothing; payload types come from b64d_pkg at instantiation.
interface b64d_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/b64d_front.sv */
// Front end: accepts characters, tracks group state, issues group commands.
// Depends on b64d_pkg and b64d_chan_if.
module b64d_front (
    input  logic                 clk,
    input  logic                 rst_n,
    b64d_chan_if.sink            chars,
    input  logic                 queue_full,
    output logic                 push,
    output b64d_pkg::group_cmd_t cmd
);
    import b64d_pkg::*;

    logic [17:0] accum_reg, accum_next;
    logic [1:0]  pos_reg, pos_next;
    logic        third_reg, third_next;
    logic        err_reg, err_next;

    logic [6:0]  mapped;
    logic        valid_ch;
    logic        pad;
    logic [5:0]  sv;
    logic        fin;
    logic        accept;
    logic [1:0]  nbytes;

    assign chars.ready = !queue_full;
    assign accept      = chars.valid && !queue_full;
    assign fin         = chars.data.final_char;
    assign mapped      = map_sextet(chars.data.in_char);
    assign valid_ch    = !mapped[6];
    assign pad         = chars.data.in_char == CHAR_PAD;
    assign sv          = valid_ch ? mapped[5:0] : 6'd0;

    always_comb
    begin
        accum_next = accum_reg;
        pos_next   = pos_reg;
        third_next = third_reg;
        err_next   = err_reg;
        nbytes     = 2'd0;
        if (pos_reg != 2'd3)
        begin
            if (pos_reg == 2'd2 && pad)
            begin
                third_next = 1'b1;
            end
            else
            begin
                if (!valid_ch)
                begin
                    err_next = 1'b1;
                end
                if (pos_reg == 2'd2)
                begin
                    third_next = 1'b0;
                end
            end
            accum_next = {accum_reg[11:0], sv};
            pos_next   = pos_reg + 2'd1;
        end
        else
        begin
            if (fin && third_reg && pad)
            begin
                nbytes = 2'd1;
            end
            else if (fin && !third_reg && pad)
            begin
                nbytes = 2'd2;
            end
            else if (third_reg || !valid_ch)
            begin
                err_next = 1'b1;
            end
            else
            begin
                nbytes = 2'd3;
            end
            if (err_next)
            begin
                nbytes = 2'd0;
            end
            accum_next = '0;
            pos_next   = 2'd0;
            third_next = 1'b0;
        end

        cmd.triple = {accum_reg, sv};
        cmd.nbytes = nbytes;
        cmd.eor    = fin;
        if (pos_reg != 2'd3)
        begin
            cmd.status = ST_BAD_LENGTH;
        end
        else if (err_next)
        begin
            cmd.status = ST_BAD_CHAR;
        end
        else
        begin
            cmd.status = ST_OK;
        end

        // End of string: drop all group state
        if (fin)
        begin
            accum_next = '0;
            pos_next   = 2'd0;
            third_next = 1'b0;
            err_next   = 1'b0;
        end
    end

    assign push = accept && (fin || nbytes != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg <= '0;
            pos_reg   <= '0;
            third_reg <= 1'b0;
            err_reg   <= 1'b0;
        end
        else if (accept)
        begin
            accum_reg <= accum_next;
            pos_reg   <= pos_next;
            third_reg <= third_next;
            err_reg   <= err_next;
        end
    end

endmodule

/* hw/rtl/b64d_queue.sv */
// Short command queue between front and back end.
// Depends on b64d_pkg.
module b64d_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  b64d_pkg::group_cmd_t wr_cmd,
    input  logic                 pop,
    output b64d_pkg::group_cmd_t head,
    output logic                 not_empty,
    output logic                 full
);
    import b64d_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    group_cmd_t      mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign not_empty = count_reg != CW'(0);
    assign full      = count_reg == CW'(DEPTH);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

/* hw/rtl/b64d_back.sv */
// Back end: unpacks group commands into result items, one per cycle while results
// are taken, through an output register. Depends on b64d_pkg and b64d_chan_if.
module b64d_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  b64d_pkg::group_cmd_t head,
    input  logic                 not_empty,
    output logic                 pop,
    b64d_chan_if.source          results
);
    import b64d_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg, out_next;
    logic       load;
    logic       last;
    logic [7:0] sel_byte;

    assign load = !out_valid_reg || results.ready;

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = head.triple[23:16];
            2'd1:    sel_byte = head.triple[15:8];
            default: sel_byte = head.triple[7:0];
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        pop            = 1'b0;
        last           = (head.nbytes == 2'd0) || (idx_reg == head.nbytes - 2'd1);
        if (load)
        begin
            out_valid_next = not_empty;
            if (not_empty)
            begin
                if (head.nbytes == 2'd0)
                begin
                    out_next.out_byte   = 8'd0;
                    out_next.byte_valid = 1'b0;
                end
                else
                begin
                    out_next.out_byte   = sel_byte & BYTE_MASK;
                    out_next.byte_valid = 1'b1;
                end
                out_next.end_of_run = last && head.eor;
                out_next.status     = (last && head.eor) ? head.status : ST_OK;
                if (last)
                begin
                    pop      = 1'b1;
                    idx_next = 2'd0;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
        end
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

/* hw/rtl/base64url_padded_decoder_unit.sv */
// Top level of the padded base64url decoder.
// Depends on b64d_pkg, b64d_chan_if, b64d_front, b64d_queue and b64d_back.

// The decoder takes one character request per clock on chars and gives
// decoded bytes on results, one per clock, through a registered output.
// Characters use the URL-safe alphabet with '=' padding; final_char marks
// the last character of a string. The front end classifies each character
// in the cycle it is accepted and, on a fourth character that yields bytes
// or on the final character, hands a group command to a small queue
// (QUEUE_DEPTH entries). The back end turns each command into up to three
// result items, so a full group of four characters yields three and the
// input keeps its one-character-per-clock rate while results are taken.
// chars.ready falls only when the queue is full, i.e. when results are held
// back for long enough. The last result of a string carries end_of_run and
// the status: ok, bad length (overriding everything else) or invalid
// character. A string whose final group yields no bytes ends with a single
// result with byte_valid low. Once an invalid character is seen, drop all
// further bytes of that string.
module base64url_padded_decoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    b64d_chan_if.sink    chars,
    b64d_chan_if.source  results
);
    import b64d_pkg::*;

    group_cmd_t push_cmd;
    group_cmd_t head_cmd;
    logic       push;
    logic       pop;
    logic       not_empty;
    logic       full;

    // Classify characters and track group state
    b64d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .queue_full (full),
        .push       (push),
        .cmd        (push_cmd)
    );

    // Hold pending group commands so each side can stall on its own
    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_cmd    (push_cmd),
        .pop       (pop),
        .head      (head_cmd),
        .not_empty (not_empty),
        .full      (full)
    );

    // Advance through the bytes of the head command
    b64d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head_cmd),
        .not_empty (not_empty),
        .pop       (pop),
        .results   (results)
    );

endmodule

/* dv/base64url_padded_decoder_unit_checker.sv */
// Checker for the padded base64url decoder: watches the character and
// result channels, decodes each character request and compares results.
// Depends on b64d_pkg and b64d_chan_if.
module base64url_padded_decoder_unit_checker
    import b64d_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    b64d_chan_if  chars,
    b64d_chan_if  results,
    output int    errors,
    output int    pending
);

    logic [17:0] acc;
    logic [1:0]  grp_pos;
    logic        pad3;
    logic        bad_seen;
    out_item_t   decoded_q[$];

    initial errors = 0;

    // Bit 6 marks a character outside the URL-safe alphabet
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        r = 7'h40;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b0, 6'(c - 8'h41)};
        end
        else if (c >= 8'h61 && c <= 8'h7A) begin
            r = {1'b0, 6'(c - 8'h61 + 8'd26)};
        end
        else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, 6'(c - 8'h30 + 8'd52)};
        end
        else if (c == CHAR_DASH) begin
            r = {1'b0, SEXTET_DASH};
        end
        else if (c == CHAR_UNDERSCORE) begin
            r = {1'b0, SEXTET_UNDERSCORE};
        end
        return r;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("%0t decode check: %s got %0h want %0h", $time, what, got, want);
        errors++;
    endtask

    task automatic decode_char(input logic [7:0] c, input logic fin);
        logic [6:0]  sx;
        logic        ok;
        logic        pad;
        logic [5:0]  sv;
        logic [1:0]  pos;
        logic [23:0] triple;
        int          nbytes;
        int          n;
        out_item_t   outs[3];
        sx     = sextet_of(c);
        ok     = !sx[6];
        pad    = (c == CHAR_PAD);
        sv     = ok ? sx[5:0] : 6'd0;
        pos    = grp_pos;
        nbytes = 0;
        n      = 0;
        if (pos != 2'd3) begin
            if (pos == 2'd2 && pad) begin
                pad3 = 1'b1;
            end
            else begin
                if (!ok) begin
                    bad_seen = 1'b1;
                end
                if (pos == 2'd2) begin
                    pad3 = 1'b0;
                end
            end
            acc     = {acc[11:0], sv};
            grp_pos = pos + 2'd1;
        end
        else begin
            triple = {acc, sv};
            if (fin && pad) begin
                nbytes = pad3 ? 1 : 2;
            end
            else if (pad3 || !ok) begin
                bad_seen = 1'b1;
            end
            else begin
                nbytes = 3;
            end
            if (bad_seen) begin
                nbytes = 0;
            end
            for (int b = 0; b < nbytes; b++) begin
                outs[n] = '{out_byte: triple[23 - 8 * b -: 8], byte_valid: 1'b1,
                            status: ST_OK, end_of_run: 1'b0};
                n++;
            end
            acc     = '0;
            grp_pos = '0;
            pad3    = 1'b0;
        end
        if (fin) begin
            if (n == 0) begin
                outs[0] = '0;
                n       = 1;
            end
            outs[n - 1].status     = (pos != 2'd3) ? ST_BAD_LENGTH
                                   : (bad_seen ? ST_BAD_CHAR : ST_OK);
            outs[n - 1].end_of_run = 1'b1;
            acc      = '0;
            grp_pos  = '0;
            pad3     = 1'b0;
            bad_seen = 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            decoded_q.push_back(outs[i]);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        out_item_t got;
        out_item_t want;
        if (!rst_n) begin
            acc      = '0;
            grp_pos  = '0;
            pad3     = 1'b0;
            bad_seen = 1'b0;
            decoded_q.delete();
            pending <= 0;
        end
        else begin
            // compare first: a result never belongs to a request taken at this edge
            if (results.valid && results.ready) begin
                got = results.data;
                if (decoded_q.size() == 0) begin
                    report("result with nothing waiting", int'(got), 0);
                end
                else begin
                    want = decoded_q.pop_front();
                    if (got.out_byte !== want.out_byte) begin
                        report("out_byte", int'(got.out_byte), int'(want.out_byte));
                    end
                    if (got.byte_valid !== want.byte_valid) begin
                        report("byte_valid", int'(got.byte_valid), int'(want.byte_valid));
                    end
                    if (got.status !== want.status) begin
                        report("status", int'(got.status), int'(want.status));
                    end
                    if (got.end_of_run !== want.end_of_run) begin
                        report("end_of_run", int'(got.end_of_run), int'(want.end_of_run));
                    end
                end
            end
            if (chars.valid && chars.ready) begin
                decode_char(chars.data.in_char, chars.data.final_char);
            end
            pending <= decoded_q.size();
        end
    end

endmodule

/* dv/base64url_padded_decoder_unit_test.sv */
// Testbench top for the padded base64url decoder: clock, reset, character
// stimulus and result back-pressure, with the checker beside the block.
// Depends on b64d_pkg, b64d_chan_if and base64url_padded_decoder_unit_checker.
module base64url_padded_decoder_unit_test;
    import b64d_pkg::*;

    typedef logic [7:0] char_q_t[$];

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_ITEMS = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    int send_idle_pct = 13;
    int recv_idle_pct = 61;
    bit hold_req = 1'b0;
    bit hold_off = 1'b0;
    int cycle_count = 0;
    int items_sent = 0;
    int failures;
    int pending;

    always #1 clk = ~clk;

    b64d_chan_if #(.T(in_item_t))  chars_if ();
    b64d_chan_if #(.T(out_item_t)) results_if ();

    base64url_padded_decoder_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (results_if)
    );

    base64url_padded_decoder_unit_checker decode_chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (results_if),
        .errors  (failures),
        .pending (pending)
    );

    // Start every input at a known value before the first edge
    initial
    begin
        chars_if.valid   = 1'b0;
        chars_if.data    = '0;
        results_if.ready = 1'b0;
    end

    // Receiver: stall at random, or hold ready low for the whole hold-off
    always @(negedge clk)
    begin
        results_if.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // Hold-off: once asked, keep the receiver stalled while the sender keeps
    // offering requests, so the queue fills up
    initial
    begin
        wait (hold_req);
        @(negedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog: abandon the run if it hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("base64url_padded_decoder_unit_test: done, errors");
            $finish;
        end
    end

    function automatic logic [7:0] alpha(input int idx);
        if (idx < 26)
        begin
            return 8'(8'h41 + idx);
        end
        else if (idx < 52)
        begin
            return 8'(8'h61 + idx - 26);
        end
        else if (idx < 62)
        begin
            return 8'(8'h30 + idx - 52);
        end
        else if (idx == 62)
        begin
            return CHAR_DASH;
        end
        return CHAR_UNDERSCORE;
    endfunction

    // Well-formed string of whole groups; the last group may end in
    // one or two padding characters
    function automatic char_q_t well_formed(input int groups);
        char_q_t s;
        int      tail;
        for (int i = 0; i < 4 * groups; i++)
        begin
            s.push_back(alpha($urandom_range(63)));
        end
        tail = $urandom_range(2);
        if (tail >= 1)
        begin
            s[s.size() - 1] = CHAR_PAD;
        end
        if (tail == 2)
        begin
            s[s.size() - 2] = CHAR_PAD;
        end
        return s;
    endfunction

    // Broken strings: raw bytes, a stray byte or padding in a random place,
    // or a length that is not a whole number of groups
    function automatic char_q_t noisy();
        char_q_t s;
        int      len;
        case ($urandom_range(3))
            0:
            begin
                len = $urandom_range(1, 9);
                for (int i = 0; i < len; i++)
                begin
                    s.push_back(8'($urandom_range(255)));
                end
            end
            1:
            begin
                s = well_formed($urandom_range(1, 3));
                s[$urandom_range(s.size() - 1)] = 8'($urandom_range(255));
            end
            2:
            begin
                s = well_formed($urandom_range(1, 3));
                s[$urandom_range(s.size() - 1)] = CHAR_PAD;
            end
            default:
            begin
                s = well_formed($urandom_range(1, 3));
                if ($urandom_range(1) == 0)
                begin
                    void'(s.pop_back());
                end
                else
                begin
                    s.push_back(alpha($urandom_range(63)));
                end
            end
        endcase
        return s;
    endfunction

    // Offer one character request at the falling edge, idling at random
    // first, and hold it until it is taken
    task automatic send_char(input logic [7:0] c, input logic fin);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            chars_if.valid <= 1'b0;
            @(negedge clk);
        end
        chars_if.data  <= '{in_char: c, final_char: fin};
        chars_if.valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!(chars_if.valid && chars_if.ready));
        items_sent++;
    endtask

    task automatic send_string(input char_q_t s);
        for (int i = 0; i < s.size(); i++)
        begin
            send_char(s[i], i == s.size() - 1);
        end
    endtask

    task automatic send_text(input string t);
        char_q_t s;
        for (int i = 0; i < t.len(); i++)
        begin
            s.push_back(t[i]);
        end
        send_string(s);
    endtask

    // Pause the sender until every predicted result has come out
    task automatic drain();
        @(negedge clk);
        chars_if.valid <= 1'b0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Mostly well-formed strings with random content, the rest broken
    task automatic random_phase(input int count);
        int start;
        start = items_sent;
        while (items_sent - start < count)
        begin
            if ($urandom_range(9) < 8)
            begin
                send_string(well_formed($urandom_range(1, 3)));
            end
            else
            begin
                send_string(noisy());
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed strings: all-ones group, one and two bytes from padding
        // over the alphabet's edges, a lone final character, padding in the
        // third place of a full group, a character outside the alphabet,
        // and a short string with a bad character where length must win
        send_text("____");
        send_text("az==");
        send_text("-09=");
        send_text("A");
        send_text("AB=C");
        send_text("Z*AA");
        send_text("*A");
        drain();

        // Phase one: sender idles rarely, receiver often
        random_phase(PHASE_ITEMS);
        drain();

        // Phase two: the other way round
        @(posedge clk);
        send_idle_pct = 61;
        recv_idle_pct = 13;
        random_phase(PHASE_ITEMS);
        drain();

        // Phase three: no idling, with a long receiver hold-off against a
        // long string so that the block fills up and stalls its input
        @(posedge clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        send_string(well_formed(8));
        random_phase(PHASE_ITEMS);
        drain();

        repeat (20) @(posedge clk);
        if (failures == 0 && pending == 0)
        begin
            $display("base64url_padded_decoder_unit_test: done, clean");
        end
        else
        begin
            $display("base64url_padded_decoder_unit_test: done, errors");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_chan_if.sv
hw/rtl/b64d_front.sv
hw/rtl/b64d_queue.sv
hw/rtl/b64d_back.sv
hw/rtl/base64url_padded_decoder_unit.sv
dv/base64url_padded_decoder_unit_checker.sv
dv/base64url_padded_decoder_unit_test.sv
